/* rtl/core/lpd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the length-prefixed message deframer.
// No dependencies; the parser, result register, top level and bench import this package.
package lpd_pkg;

  // Header layout: one code byte, then a 4-byte little-endian total length
  localparam logic [2:0]  HDR_BYTES    = 3'd5;
  localparam logic [2:0]  HDR_LAST_IDX = 3'd4;
  localparam logic [31:0] HDR_LEN      = 32'd5;
  // Byte count at which the 4-byte frame index is complete
  localparam logic [31:0] INDEX_DONE   = 32'd9;
  localparam int          LANES        = 4;

  // One accepted input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } lpd_beat_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_content;
    logic [7:0]  msg_code;
    logic        msg_end;
    logic        spill;
    logic        length_error;
    logic        frame_index_valid;
    logic [31:0] frame_index;
  } lpd_result_t;

endpackage

/* rtl/core/lpd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: byte input and result output.
// Standalone; field names follow the block's input and result fields.
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_content;
  logic [7:0]  msg_code;
  logic        msg_end;
  logic        spill;
  logic        length_error;
  logic        frame_index_valid;
  logic [31:0] frame_index;

  modport source (output valid, output out_byte, output is_content, output msg_code,
                  output msg_end, output spill, output length_error,
                  output frame_index_valid, output frame_index, input ready);
  modport sink   (input valid, input out_byte, input is_content, input msg_code,
                  input msg_end, input spill, input length_error,
                  input frame_index_valid, input frame_index, output ready);
endinterface

/* rtl/core/lpd_parser.sv */
`timescale 1ns / 1ps
// Message parser: header counter, length and frame index registers, and the
// per-beat result logic. Depends on lpd_pkg.
module lpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lpd_pkg::lpd_beat_t  beat_i,
  output lpd_pkg::lpd_result_t res_o
);
  import lpd_pkg::*;

  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] tot_len_r, tot_len_nxt;
  logic [31:0] rcvd_r, rcvd_nxt;
  logic [31:0] idx_acc_r, idx_acc_nxt;
  logic        idx_vld_r, idx_vld_nxt;

  logic        in_header;
  logic        msg_end;
  logic        len_err;
  logic [1:0]  len_lane;
  logic [1:0]  idx_lane;
  logic [2:0]  hdr_cnt_inc;
  logic [31:0] rcvd_inc;
  logic [31:0] rcvd_lane;

  assign in_header   = (hdr_cnt_r < HDR_BYTES);
  assign hdr_cnt_inc = hdr_cnt_r + 3'd1;
  assign rcvd_inc    = rcvd_r + 32'd1;
  assign rcvd_lane   = rcvd_r - HDR_LEN;
  assign len_lane    = hdr_cnt_r[1:0] - 2'd1;
  assign idx_lane    = rcvd_lane[1:0];

  // Advance header/content state for one beat
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    code_nxt    = code_r;
    tot_len_nxt = tot_len_r;
    rcvd_nxt    = rcvd_r;
    idx_acc_nxt = idx_acc_r;
    idx_vld_nxt = idx_vld_r;
    msg_end     = 1'b0;
    len_err     = 1'b0;
    if (in_header) begin
      if (hdr_cnt_r == 3'd0) begin
        code_nxt    = beat_i.in_byte;
        tot_len_nxt = '0;
        idx_acc_nxt = '0;
        idx_vld_nxt = 1'b0;
      end else begin
        for (int i = 0; i < LANES; i++) begin
          if (len_lane == 2'(i)) begin
            tot_len_nxt[i*8 +: 8] = tot_len_r[i*8 +: 8] | beat_i.in_byte;
          end
        end
      end
      hdr_cnt_nxt = hdr_cnt_inc;
      rcvd_nxt    = {29'd0, hdr_cnt_inc};
      if (hdr_cnt_r == HDR_LAST_IDX && tot_len_nxt <= HDR_LEN) begin
        msg_end = 1'b1;
        len_err = (tot_len_nxt < HDR_LEN);
      end
    end else begin
      // Gather the first four content bytes as the frame index
      if (rcvd_r < INDEX_DONE) begin
        for (int i = 0; i < LANES; i++) begin
          if (idx_lane == 2'(i)) begin
            idx_acc_nxt[i*8 +: 8] = idx_acc_r[i*8 +: 8] | beat_i.in_byte;
          end
        end
        if (rcvd_inc == INDEX_DONE) begin
          idx_vld_nxt = 1'b1;
        end
      end
      rcvd_nxt = rcvd_inc;
      msg_end  = (rcvd_inc >= tot_len_r);
    end
    // Drop back to header parsing once the message completes
    if (msg_end) begin
      hdr_cnt_nxt = '0;
      rcvd_nxt    = '0;
    end
  end

  // Build the result beat from the updated state
  always_comb begin
    res_o.out_byte          = beat_i.in_byte;
    res_o.is_content        = !in_header;
    res_o.msg_code          = code_nxt;
    res_o.msg_end           = msg_end;
    res_o.spill             = msg_end && !beat_i.chunk_end;
    res_o.length_error      = len_err;
    res_o.frame_index_valid = idx_vld_nxt;
    res_o.frame_index       = idx_vld_nxt ? idx_acc_nxt : '0;
  end

  // Hold state between beats, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      code_r    <= '0;
      tot_len_r <= '0;
      rcvd_r    <= '0;
      idx_acc_r <= '0;
      idx_vld_r <= 1'b0;
    end else if (step) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      code_r    <= code_nxt;
      tot_len_r <= tot_len_nxt;
      rcvd_r    <= rcvd_nxt;
      idx_acc_r <= idx_acc_nxt;
      idx_vld_r <= idx_vld_nxt;
    end
  end

endmodule

/* rtl/core/lpd_out_stage.sv */
`timescale 1ns / 1ps
// Result register: holds one result beat until the receiver takes it.
// Depends on lpd_pkg.
module lpd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  lpd_pkg::lpd_result_t res_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 out_ready,
  output lpd_pkg::lpd_result_t res_o
);
  import lpd_pkg::*;

  logic        valid_r;
  lpd_result_t data_r;

  // Take a new beat when empty or when the held beat leaves this cycle
  assign ready_o = !valid_r || out_ready;
  assign valid_o = valid_r;
  assign res_o   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= load;
    end
  end

  // Payload: load only, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_i;
    end
  end

endmodule

/* rtl/core/length_prefixed_message_deframer.sv */
`timescale 1ns / 1ps
// Length-prefixed message deframer, top level.
// Input channel in_ch carries one stream byte per beat plus a chunk_end flag.
// Each message is a code byte, a 4-byte little-endian total length (header
// included), then content. The result channel out_ch returns one beat per
// input beat: the byte, header/content flag, message code, end-of-message,
// spill (message ended before its chunk did), length error (length below 5)
// and the frame index made of the first four content bytes.
// The result is valid in the cycle after input accept; one byte per cycle
// sustained while out_ch.ready is high. The rate is set by the single result
// register: the parser state updates in the accepting cycle and the result
// lands in that register. A new beat is taken while the held result leaves in
// the same cycle. Receiver stall: the result register holds its beat and
// in_ch.ready drops until out_ch.ready returns; no beat is lost or repeated.
// Reset (rst_n low, synchronous): the parser waits for a code byte, the
// frame index clears and no result is pending.
// Depends on lpd_pkg, lpd_if, lpd_parser and lpd_out_stage.
module length_prefixed_message_deframer (
  input  logic clk,
  input  logic rst_n,
  lpd_in_if.sink    in_ch,
  lpd_out_if.source out_ch
);
  import lpd_pkg::*;

  logic        step;
  logic        stage_ready;
  logic        stage_valid;
  lpd_beat_t   beat;
  lpd_result_t res_comb;
  lpd_result_t res_held;

  assign in_ch.ready = stage_ready;
  assign step        = in_ch.valid && stage_ready;
  assign beat        = '{in_byte: in_ch.in_byte, chunk_end: in_ch.chunk_end};

  lpd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .beat_i (beat),
    .res_o  (res_comb)
  );

  lpd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_i     (res_comb),
    .ready_o   (stage_ready),
    .valid_o   (stage_valid),
    .out_ready (out_ch.ready),
    .res_o     (res_held)
  );

  // Drive the result channel from the held beat
  assign out_ch.valid             = stage_valid;
  assign out_ch.out_byte          = res_held.out_byte;
  assign out_ch.is_content        = res_held.is_content;
  assign out_ch.msg_code          = res_held.msg_code;
  assign out_ch.msg_end           = res_held.msg_end;
  assign out_ch.spill             = res_held.spill;
  assign out_ch.length_error      = res_held.length_error;
  assign out_ch.frame_index_valid = res_held.frame_index_valid;
  assign out_ch.frame_index       = res_held.frame_index;

endmodule

/* rtl/core/lpd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the deframer's result channel, bound to the top level.
// Depends on length_prefixed_message_deframer and the lpd_if interfaces.
module lpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        is_content,
  input logic        msg_end,
  input logic        spill,
  input logic        length_error,
  input logic        frame_index_valid,
  input logic [31:0] frame_index
);

  // Stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(msg_end)
      && $stable(frame_index))
    else $error("stalled result beat changed");

  // A full, stalled result register blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Length error ends the message on a header beat
  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && length_error |-> msg_end && !is_content && !frame_index_valid)
    else $error("length error without header end");

  // Header beats never carry a frame index
  a_hdr_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_content |-> !frame_index_valid && (frame_index == 32'd0))
    else $error("frame index shown on header beat");

  // Spill only where a message ends
  a_spill_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && spill |-> msg_end)
    else $error("spill without message end");

endmodule

bind length_prefixed_message_deframer lpd_checker u_lpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_byte          (out_ch.out_byte),
  .is_content        (out_ch.is_content),
  .msg_end           (out_ch.msg_end),
  .spill             (out_ch.spill),
  .length_error      (out_ch.length_error),
  .frame_index_valid (out_ch.frame_index_valid),
  .frame_index       (out_ch.frame_index)
);

/* tb/tb_length_prefixed_message_deframer.sv */
`timescale 1ns / 1ps
// Self-checking bench for length_prefixed_message_deframer: drives framed byte streams
// and checks every result beat against a per-byte model of the header/content parser.
// Depends on lpd_pkg, lpd_if and the deframer RTL.

// Tracks the parser state per accepted byte and holds the beats it expects back
class deframe_scoreboard;
  logic [2:0]  hdr_taken;
  logic [7:0]  code;
  logic [31:0] msg_len;
  logic [31:0] byte_pos;
  logic [31:0] index_acc;
  logic        index_ok;
  lpd_pkg::lpd_result_t expected_beats[$];
  int unsigned errors;

  function new();
    hdr_taken = '0;
    code      = '0;
    msg_len   = '0;
    byte_pos  = '0;
    index_acc = '0;
    index_ok  = 1'b0;
    errors    = 0;
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction

  // Advance the parser by one accepted byte and queue the beat it must produce
  function void take_byte(logic [7:0] b, logic ce);
    lpd_pkg::lpd_result_t r;
    logic is_body;
    logic done;
    logic bad_len;
    int   sh;
    is_body = 1'b0;
    done    = 1'b0;
    bad_len = 1'b0;
    if (hdr_taken < lpd_pkg::HDR_BYTES) begin
      // Code byte opens a message and clears the index; length bytes are LE
      if (hdr_taken == 3'd0) begin
        code      = b;
        msg_len   = '0;
        index_acc = '0;
        index_ok  = 1'b0;
      end else begin
        sh = 8 * (int'(hdr_taken) - 1);
        msg_len = msg_len | (32'(b) << sh);
      end
      hdr_taken = hdr_taken + 3'd1;
      byte_pos  = 32'(hdr_taken);
      if (hdr_taken == lpd_pkg::HDR_BYTES && msg_len <= lpd_pkg::HDR_LEN) begin
        done    = 1'b1;
        bad_len = (msg_len < lpd_pkg::HDR_LEN);
      end
    end else begin
      is_body = 1'b1;
      // First four content bytes build the frame index
      if (byte_pos < lpd_pkg::INDEX_DONE) begin
        sh = 8 * int'(byte_pos - lpd_pkg::HDR_LEN);
        index_acc = index_acc | (32'(b) << sh);
        if (byte_pos + 32'd1 == lpd_pkg::INDEX_DONE) index_ok = 1'b1;
      end
      byte_pos = byte_pos + 32'd1;
      if (byte_pos >= msg_len) done = 1'b1;
    end
    r.out_byte          = b;
    r.is_content        = is_body;
    r.msg_code          = code;
    r.msg_end           = done;
    r.spill             = done & ~ce;
    r.length_error      = bad_len;
    r.frame_index_valid = index_ok;
    r.frame_index       = index_ok ? index_acc : 32'd0;
    expected_beats.push_back(r);
    if (done) begin
      hdr_taken = '0;
      byte_pos  = '0;
    end
  endfunction

  function void check_field(string field_name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
      errors++;
    end
  endfunction

  // Compare one result beat with the oldest expectation
  function void check_beat(lpd_pkg::lpd_result_t got);
    lpd_pkg::lpd_result_t want;
    if (expected_beats.size() == 0) begin
      $error("result beat with no expectation: out_byte 0x%0h", got.out_byte);
      errors++;
      return;
    end
    want = expected_beats.pop_front();
    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
    check_field("is_content", 32'(want.is_content), 32'(got.is_content));
    check_field("msg_code", 32'(want.msg_code), 32'(got.msg_code));
    check_field("msg_end", 32'(want.msg_end), 32'(got.msg_end));
    check_field("spill", 32'(want.spill), 32'(got.spill));
    check_field("length_error", 32'(want.length_error), 32'(got.length_error));
    check_field("frame_index_valid", 32'(want.frame_index_valid),
                32'(got.frame_index_valid));
    check_field("frame_index", want.frame_index, got.frame_index);
  endfunction
endclass

module tb_length_prefixed_message_deframer;
  import lpd_pkg::*;

  localparam int PHASE_BEATS     = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 50000;
  localparam int TAIL_BEATS      = 40;

  logic clk;
  logic rst_n;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  length_prefixed_message_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard board;
  lpd_result_t       seen;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_off_requests;
  int unsigned beats_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_length_prefixed_message_deframer: errors");
    $finish;
  end

  // Note accepted bytes first, then check any result beat taken at this edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      board.take_byte(in_ch.in_byte, in_ch.chunk_end);
    end
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.out_byte          = out_ch.out_byte;
      seen.is_content        = out_ch.is_content;
      seen.msg_code          = out_ch.msg_code;
      seen.msg_end           = out_ch.msg_end;
      seen.spill             = out_ch.spill;
      seen.length_error      = out_ch.length_error;
      seen.frame_index_valid = out_ch.frame_index_valid;
      seen.frame_index       = out_ch.frame_index;
      board.check_beat(seen);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned served;
    int unsigned held;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_requests != served) begin
        served++;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      out_ch.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic logic chunk_flag(int unsigned pct);
    return ($urandom_range(99, 0) < pct);
  endfunction

  // Offer one byte and hold it until the beat is taken; called at a rising edge
  task automatic put_byte(logic [7:0] b, logic ce);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.chunk_end <= ce;
    @(negedge clk);
    while (in_ch.ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  // Header: code byte then LE length; bit i of ce_mask marks chunk end on byte i
  task automatic send_header(logic [7:0] code, logic [31:0] len, logic [4:0] ce_mask);
    put_byte(code, ce_mask[0]);
    put_byte(len[7:0], ce_mask[1]);
    put_byte(len[15:8], ce_mask[2]);
    put_byte(len[23:16], ce_mask[3]);
    put_byte(len[31:24], ce_mask[4]);
  endtask

  task automatic send_message(logic [7:0] code, int unsigned len, int unsigned ce_pct);
    logic [4:0] mask;
    for (int i = 0; i < 5; i++) mask[i] = chunk_flag(ce_pct);
    send_header(code, 32'(len), mask);
    for (int unsigned i = 5; i < len; i++) put_byte(8'($urandom), chunk_flag(ce_pct));
  endtask

  // Mostly short messages around the frame-index boundary, some bad lengths, a few long
  task automatic send_random_message();
    int unsigned pick;
    int unsigned len;
    int unsigned ce_pct;
    pick = $urandom_range(99, 0);
    if (pick < 8) len = $urandom_range(4, 0);
    else if (pick < 88) len = $urandom_range(24, 5);
    else if (pick < 98) len = $urandom_range(80, 25);
    else len = $urandom_range(700, 200);
    case ($urandom_range(3, 0))
      0:       ce_pct = 0;
      1:       ce_pct = 15;
      2:       ce_pct = 50;
      default: ce_pct = 100;
    endcase
    send_message(8'($urandom), len, ce_pct);
  endtask

  // Stop offering and wait for every expected beat, then let the pipe settle
  task automatic wait_drained();
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned target;
    board             = new();
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_off_requests = 0;
    beats_sent        = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.chunk_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero length: error after the header, chunk breaks mid-header, message spills
    send_header(8'h00, 32'd0, 5'b00010);
    // Length 4: error, ends together with its chunk
    send_header(8'hA5, 32'd4, 5'b10000);
    // Length exactly 5: header only, no content, no index
    send_header(8'h5A, 32'd5, 5'b00000);
    // Length 9: four content bytes, index valid on the last one
    send_header(8'hFF, 32'd9, 5'b00100);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    put_byte(8'h7F, 1'b0);
    put_byte(8'h80, 1'b1);
    wait_drained();

    // Random traffic under four idle profiles; drain between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_off_requests++;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 85;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct     = 17;
        end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) send_random_message();
      wait_drained();
    end

    // Maximum length: every length bit set, the message never completes
    send_idle_pct = 17;
    stall_pct     = 17;
    send_header(8'($urandom), 32'hFFFF_FFFF, 5'($urandom));
    for (int i = 0; i < TAIL_BEATS; i++) put_byte(8'($urandom), chunk_flag(30));
    wait_drained();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_length_prefixed_message_deframer: clean");
    end else begin
      if (board.pending() != 0) begin
        $error("%0d expected beats never arrived", board.pending());
      end
      $display("tb_length_prefixed_message_deframer: errors");
    end
    $finish;
  end

endmodule
